// ===== src/pnsm_pkg.sv =====
// package of the peak normalized stereo mixdown: constants, codes and types
`default_nettype none
package pnsm_pkg;

  localparam int MaxTracks  = 8;
  localparam int MaxFrames  = 4096;
  localparam int SampleBits = 16;
  localparam int TrkIdxW    = $clog2(MaxTracks);
  localparam int FrmIdxW    = $clog2(MaxFrames);
  localparam int DivW       = 52;
  localparam int DivisorW   = 32;

  typedef enum logic [1:0] {
    KindSet    = 2'd0,
    KindSample = 2'd1,
    KindRun    = 2'd2,
    KindRead   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatRange = 2'd1,
    StatNoMix = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CfgTrackCount  = 2'd0,
    CfgSampleCount = 2'd1,
    CfgMasterGain  = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    StIdle, StClr, StSum, StTrk, StScA, StScB, StWStart, StWWait, StEStart, StEWait,
    StF0, StFWait, StPow, StPowB, StMul, StPkA, StPkB, StFs, StFsWait,
    StRd0, StRd1, StRd2
  } state_e;

  typedef struct packed {
    logic [15:0]        amp;
    logic [12:0]        fin;
    logic [12:0]        fout;
    logic [2:0]         curve;
    logic [12:0]        offset;
    logic signed [15:0] pan;
    logic               present;
  } trk_cfg_t;

endpackage
`default_nettype wire

// ===== src/pnsm_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module pnsm_div import pnsm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DivW-1:0]     dividend_i,
  input  wire logic [DivisorW-1:0] divisor_i,
  output logic                     done_o,
  output logic [DivW-1:0]          quotient_o
);

  localparam int CntW = $clog2(DivW);

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DivW-1:0]     dvd_q;
  logic [DivisorW-1:0] rem_q, dvs_q;
  logic [DivisorW:0]   rem_sh, rem_sub;
  logic                ge;

  assign rem_sh  = {rem_q, dvd_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[DivW-2:0], ge};
        rem_q <= ge ? rem_sub[DivisorW-1:0] : rem_sh[DivisorW-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
`default_nettype wire

// ===== src/peak_normalized_stereo_mixdown.sv =====
// top level of the peak normalized stereo mixdown: sequencer, memories, shared multiplier
//
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       tuser kind, tdata track..track_present
// m_axis    out        m_axis_tvalid/tready       tdata status, left, right, global_peak
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// settings, sample writes and refused items: result word registered in the cycle after acceptance
// reads: mix word read on acceptance, then StRd0, StRd1 and StRd2 scale left and right through the shared multiplier
// run: clears the mix memory, then per track a peak scan, the weight divisions and per
// frame the fade envelope (divider) and the mixing products, then the global peak and
// the final scale; divisions run on the shared divider, products on the shared
// multiplier. reset clears control and datapath registers, not the track settings or
// the memories; a stalled result word holds the block idle until taken
`default_nettype none
module peak_normalized_stereo_mixdown import pnsm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // track, sample_index, left_in, right_in, amplitude_scale, fade_in, fade_out,
  // curve, offset, pan, track_present
  input  wire logic [127:0] s_axis_tdata,
  // kind
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, left_out, right_out, global_peak
  output logic [55:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int SmpAddrW = TrkIdxW + FrmIdxW;

  // input decode
  kind_e              in_kind;
  logic [2:0]         in_trk;
  logic [11:0]        in_idx;
  trk_cfg_t           in_cfg;
  logic               acc;

  assign in_kind        = kind_e'(s_axis_tuser);
  assign in_trk         = s_axis_tdata[2:0];
  assign in_idx         = s_axis_tdata[14:3];
  assign in_cfg.amp     = s_axis_tdata[62:47];
  assign in_cfg.fin     = s_axis_tdata[75:63];
  assign in_cfg.fout    = s_axis_tdata[88:76];
  assign in_cfg.curve   = s_axis_tdata[91:89];
  assign in_cfg.offset  = s_axis_tdata[104:92];
  assign in_cfg.pan     = s_axis_tdata[120:105];
  assign in_cfg.present = s_axis_tdata[121];

  state_e state_q, state_d;
  assign s_axis_tready = (state_q == StIdle) && !m_axis_tvalid;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // configuration
  logic [3:0]  cfg_tracks_q;
  logic [12:0] cfg_samples_q;
  logic [15:0] cfg_master_q;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tracks_q  <= '0;
      cfg_samples_q <= '0;
      cfg_master_q  <= 16'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CfgTrackCount:  cfg_tracks_q  <= cfg_data[3:0];
        CfgSampleCount: cfg_samples_q <= cfg_data[12:0];
        CfgMasterGain:  cfg_master_q  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [12:0] n;
  logic [3:0]  tc;
  assign n  = (cfg_samples_q > 13'(MaxFrames)) ? 13'(MaxFrames) : cfg_samples_q;
  assign tc = (cfg_tracks_q > 4'(MaxTracks)) ? 4'(MaxTracks) : cfg_tracks_q;

  // track settings
  trk_cfg_t tcfg_q [MaxTracks];
  logic [3:0]  t_q;
  trk_cfg_t    cur;
  assign cur = tcfg_q[t_q[TrkIdxW-1:0]];

  always_ff @(posedge clk_i) begin
    if (acc && in_kind == KindSet && int'(in_trk) < MaxTracks)
      tcfg_q[in_trk[TrkIdxW-1:0]] <= in_cfg;
  end

  // datapath registers
  logic [12:0] i_q;
  logic [18:0] total_q, den_q;
  logic [16:0] maxamp_q, w_q, k_q, env_q;
  logic [32:0] e_q;
  logic [2:0]  pcnt_q, pw_q, ms_q;
  logic [24:0] vm_q, cl_q;
  logic [31:0] peak_q;
  logic [27:0] fs_q;
  logic        ready_q;
  logic [64:0] prod_q;
  logic [15:0] res_l_q;
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [15:0] out_l_q, out_r_q, out_peak_q;

  // sample memory
  logic [31:0]         smem [MaxTracks*MaxFrames];
  logic [31:0]         smp_rd_q;
  logic [SmpAddrW-1:0] s_ra, s_wa;
  logic                s_we;
  assign s_ra = {t_q[TrkIdxW-1:0], i_q[FrmIdxW-1:0]};
  assign s_wa = {in_trk[TrkIdxW-1:0], in_idx[FrmIdxW-1:0]};
  assign s_we = acc && in_kind == KindSample && int'(in_trk) < MaxTracks
                && int'(in_idx) < MaxFrames;

  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_wa] <= {s_axis_tdata[46:31], s_axis_tdata[30:15]};
    smp_rd_q <= smem[s_ra];
  end

  // mix memory
  logic [63:0]        mmem [MaxFrames];
  logic [63:0]        mix_rd_q, m_wd;
  logic [FrmIdxW-1:0] m_ra;
  logic               m_we;
  assign m_ra = (state_q == StIdle) ? in_idx[FrmIdxW-1:0] : i_q[FrmIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (m_we) mmem[i_q[FrmIdxW-1:0]] <= m_wd;
    mix_rd_q <= mmem[m_ra];
  end

  // sample and mix operands
  logic signed [15:0] sl, sr;
  logic [16:0]        sl_m, sr_m, amax, mx_n;
  logic [31:0]        ml, mr, ml_m, mr_m;
  assign sl   = smp_rd_q[15:0];
  assign sr   = smp_rd_q[31:16];
  assign sl_m = sl[15] ? 17'(-{1'b1, sl}) : {1'b0, sl};
  assign sr_m = sr[15] ? 17'(-{1'b1, sr}) : {1'b0, sr};
  assign amax = (sl_m < sr_m) ? sr_m : sl_m;
  assign mx_n = (amax > maxamp_q) ? amax : maxamp_q;
  assign ml   = mix_rd_q[31:0];
  assign mr   = mix_rd_q[63:32];
  assign ml_m = ml[31] ? -ml : ml;
  assign mr_m = mr[31] ? -mr : mr;

  // envelope and pan
  logic        in_fi, in_fo;
  logic [12:0] start, num, len;
  logic [2:0]  pw;
  logic [15:0] lg, rg;
  assign in_fi = (cur.fin != '0) && ({1'b0, i_q} < ({1'b0, cur.offset} + {1'b0, cur.fin}));
  assign start = (n > cur.fout) ? n - cur.fout : '0;
  assign in_fo = (cur.fout != '0) && (i_q >= start);
  assign num   = in_fi ? i_q - cur.offset : cur.fout - (i_q - start);
  assign len   = in_fi ? cur.fin : cur.fout;
  assign pw    = in_fi ? 3'd2 : (cur.curve == 3'd4) ? 3'd4 : (cur.curve == 3'd2) ? 3'd2 : 3'd3;
  assign lg    = cur.pan[15] ? 16'h8000 : 16'h8000 - cur.pan;
  assign rg    = (!cur.pan[15] && cur.pan != '0) ? 16'h8000 : 16'h8000 + cur.pan;

  // contributions
  logic [31:0] cls, crs;
  logic [24:0] cr;
  assign cr  = prod_q[55:31];
  assign cls = sl[15] ? -{7'b0, cl_q} : {7'b0, cl_q};
  assign crs = sr[15] ? -{7'b0, cr} : {7'b0, cr};
  assign m_wd = (state_q == StClr) ? '0 : {mr + crs, ml + cls};

  // output scaling
  function automatic logic [15:0] sat_out(input logic [26:0] v, input logic neg);
    logic [15:0] r;
    if (neg) r = (v > 27'd32768) ? 16'h8000 : 16'(-v);
    else     r = (v > 27'd32767) ? 16'h7fff : v[15:0];
    return r;
  endfunction

  logic [15:0] peak_o;
  assign peak_o = (peak_q[31:9] > 23'd65535) ? 16'hffff : peak_q[24:9];

  // shared divider
  logic            div_start, div_done;
  logic [DivW-1:0] div_q, dvd;
  logic [DivisorW-1:0] dvs;

  always_comb begin
    dvd = '0;
    dvs = '0;
    unique case (state_q)
      StWStart: begin dvd = DivW'({cur.amp, 16'b0});   dvs = DivisorW'(den_q);    end
      StEStart: begin dvd = DivW'({w_q, 16'b0});       dvs = DivisorW'(maxamp_q); end
      StF0:     begin dvd = DivW'({num, 16'b0});       dvs = DivisorW'(len);      end
      StFs:     begin dvd = {cfg_master_q, 36'b0};     dvs = peak_q;              end
      default: ;
    endcase
  end

  pnsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StPow: begin mul_a = 33'(env_q); mul_b = 32'(k_q); end
      StMul: begin
        unique case (ms_q)
          3'd0: begin mul_a = e_q;          mul_b = 32'(sl_m);      end
          3'd1: begin mul_a = 33'(env_q);   mul_b = 32'(lg);        end
          3'd2: begin mul_a = 33'(vm_q);    mul_b = prod_q[31:0];   end
          3'd3: begin mul_a = e_q;          mul_b = 32'(sr_m);      end
          3'd4: begin mul_a = 33'(env_q);   mul_b = 32'(rg);        end
          3'd5: begin mul_a = 33'(vm_q);    mul_b = prod_q[31:0];   end
          default: ;
        endcase
      end
      StRd0: begin mul_a = 33'(ml_m); mul_b = 32'(fs_q); end
      StRd1: begin mul_a = 33'(mr_m); mul_b = 32'(fs_q); end
      default: ;
    endcase
  end

  logic i_last;
  assign i_last = (i_q + 13'd1) == n;

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    m_we      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          unique case (in_kind)
            KindRun:  state_d = StClr;
            KindRead: if (ready_q && {1'b0, in_idx} < n) state_d = StRd0;
            default: ;
          endcase
        end
      end
      StClr: begin
        m_we = 1'b1;
        if (i_q == 13'(MaxFrames - 1)) state_d = StSum;
      end
      StSum:    if (t_q == tc) state_d = StTrk;
      StTrk: begin
        if (t_q == tc) state_d = (n == '0) ? StFs : StPkA;
        else if (cur.present && cur.offset < n) state_d = StScA;
      end
      StScA:    state_d = StScB;
      StScB: begin
        if (i_last) state_d = (mx_n == '0) ? StTrk : StWStart;
        else state_d = StScA;
      end
      StWStart: begin div_start = 1'b1; state_d = StWWait; end
      StWWait:  if (div_done) state_d = StEStart;
      StEStart: begin div_start = 1'b1; state_d = StEWait; end
      StEWait:  if (div_done) state_d = StF0;
      StF0: begin
        if (in_fi || in_fo) begin
          div_start = 1'b1;
          state_d   = StFWait;
        end else begin
          state_d = StMul;
        end
      end
      StFWait:  if (div_done) state_d = StPow;
      StPow:    state_d = StPowB;
      StPowB:   state_d = ((pcnt_q + 3'd1) == pw_q) ? StMul : StPow;
      StMul: begin
        if (ms_q == 3'd6) begin
          m_we    = 1'b1;
          state_d = i_last ? StTrk : StF0;
        end
      end
      StPkA:    state_d = StPkB;
      StPkB:    if (i_last) state_d = StFs;
                else state_d = StPkA;
      StFs: begin
        if (peak_q > 32'd16777216) begin
          div_start = 1'b1;
          state_d   = StFsWait;
        end else begin
          state_d = StIdle;
        end
      end
      StFsWait: if (div_done) state_d = StIdle;
      StRd0:    state_d = StRd1;
      StRd1:    state_d = StRd2;
      StRd2:    state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ready_q      <= 1'b0;
      peak_q       <= '0;
      fs_q         <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_l_q      <= '0;
      out_r_q      <= '0;
      out_peak_q   <= '0;
      i_q          <= '0;
      t_q          <= '0;
      total_q      <= '0;
      den_q        <= '0;
      maxamp_q     <= '0;
      w_q          <= '0;
      e_q          <= '0;
      k_q          <= '0;
      env_q        <= '0;
      pcnt_q       <= '0;
      pw_q         <= '0;
      ms_q         <= '0;
      vm_q         <= '0;
      cl_q         <= '0;
      prod_q       <= '0;
      res_l_q      <= '0;
    end else begin
      state_q <= state_d;
      prod_q  <= 65'(mul_a) * 65'(mul_b);
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            out_l_q    <= '0;
            out_r_q    <= '0;
            out_peak_q <= '0;
            i_q        <= '0;
            unique case (in_kind)
              KindSet: begin
                out_valid_q  <= 1'b1;
                out_status_q <= (int'(in_trk) < MaxTracks) ? StatOk : StatRange;
              end
              KindSample: begin
                out_valid_q  <= 1'b1;
                out_status_q <= s_we ? StatOk : StatRange;
              end
              KindRun: ;
              KindRead: begin
                i_q <= {1'b0, in_idx};
                if (!ready_q) begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= StatNoMix;
                end else if ({1'b0, in_idx} >= n) begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= StatRange;
                  out_peak_q   <= peak_o;
                end
              end
              default: ;
            endcase
          end
        end
        StClr: begin
          i_q <= i_q + 13'd1;
          if (i_q == 13'(MaxFrames - 1)) begin
            t_q     <= '0;
            total_q <= '0;
          end
        end
        StSum: begin
          if (t_q == tc) begin
            den_q <= (total_q > 19'd256) ? total_q : 19'd256;
            t_q   <= '0;
          end else begin
            total_q <= total_q + 19'(cur.amp);
            t_q     <= t_q + 4'd1;
          end
        end
        StTrk: begin
          if (t_q == tc) begin
            i_q    <= '0;
            peak_q <= '0;
          end else if (cur.present && cur.offset < n) begin
            i_q      <= cur.offset;
            maxamp_q <= '0;
          end else begin
            t_q <= t_q + 4'd1;
          end
        end
        StScB: begin
          maxamp_q <= mx_n;
          if (i_last) begin
            if (mx_n == '0) t_q <= t_q + 4'd1;
          end else begin
            i_q <= i_q + 13'd1;
          end
        end
        StWWait: if (div_done) w_q <= div_q[16:0];
        StEWait: begin
          if (div_done) begin
            e_q <= div_q[32:0];
            i_q <= cur.offset;
          end
        end
        StF0: begin
          ms_q  <= '0;
          pw_q  <= pw;
          env_q <= 17'h10000;
        end
        StFWait: begin
          if (div_done) begin
            k_q    <= div_q[16:0];
            env_q  <= div_q[16:0];
            pcnt_q <= 3'd1;
          end
        end
        StPowB: begin
          env_q  <= prod_q[32:16];
          pcnt_q <= pcnt_q + 3'd1;
        end
        StMul: begin
          ms_q <= ms_q + 3'd1;
          unique case (ms_q)
            3'd1, 3'd4: vm_q <= prod_q[32:8];
            3'd3:       cl_q <= prod_q[55:31];
            3'd6: begin
              if (i_last) t_q <= t_q + 4'd1;
              else i_q <= i_q + 13'd1;
            end
            default: ;
          endcase
        end
        StPkB: begin
          if (ml_m > peak_q && ml_m >= mr_m) peak_q <= ml_m;
          else if (mr_m > peak_q) peak_q <= mr_m;
          if (!i_last) i_q <= i_q + 13'd1;
        end
        StFs: begin
          if (!(peak_q > 32'd16777216)) begin
            fs_q         <= {cfg_master_q, 12'b0};
            ready_q      <= 1'b1;
            out_valid_q  <= 1'b1;
            out_status_q <= StatOk;
            out_peak_q   <= peak_o;
          end
        end
        StFsWait: begin
          if (div_done) begin
            fs_q         <= div_q[27:0];
            ready_q      <= 1'b1;
            out_valid_q  <= 1'b1;
            out_status_q <= StatOk;
            out_peak_q   <= peak_o;
          end
        end
        StRd1: res_l_q <= sat_out(prod_q[59:33], ml[31]);
        StRd2: begin
          out_valid_q  <= 1'b1;
          out_status_q <= StatOk;
          out_l_q      <= res_l_q;
          out_r_q      <= sat_out(prod_q[59:33], mr[31]);
          out_peak_q   <= peak_o;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_peak_q, out_r_q, out_l_q, out_status_q};

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the peak normalized stereo mixdown: directed table, then random phases
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import pnsm_pkg::*;

  localparam int CycleLimit = 4000000;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] peak;
  } mix_word_t;

  typedef struct {
    kind_e              kind;
    logic [2:0]         trk;
    logic [11:0]        idx;
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic [15:0]        amp;
    logic [12:0]        fin;
    logic [12:0]        fout;
    logic [2:0]         curve;
    logic [12:0]        off;
    logic signed [15:0] pan;
    logic               pres;
    bit                 typed;
    status_e            stat;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  // predictor state
  logic signed [15:0] smp_l [MaxTracks][MaxFrames];
  logic signed [15:0] smp_r [MaxTracks][MaxFrames];
  bit                 smp_written [MaxTracks][MaxFrames];
  trk_cfg_t           trk_set [MaxTracks];
  int                 mix_l [MaxFrames];
  int                 mix_r [MaxFrames];
  longint unsigned    out_scale;
  longint unsigned    peak_reg;
  bit                 mix_done;
  int unsigned        tc_reg, n_reg, mg_reg;

  mix_word_t pending_words[$];
  int        errors = 0;
  int        items_sent = 0;
  int        words_seen = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  bit        big_stall_done = 1'b0;
  int        hold = 0;

  always #5 clk_i = ~clk_i;

  peak_normalized_stereo_mixdown dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  function automatic longint trunc_scale(longint v, longint unsigned m, int sh);
    longint unsigned a;
    longint unsigned p;
    a = v < 0 ? longint'(-v) : v;
    p = (a * m) >> sh;
    return v < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned env_pow(longint unsigned num, longint unsigned len,
                                              int pw);
    longint unsigned k;
    longint unsigned e;
    k = (num << 16) / len;
    e = k;
    for (int p = 1; p < pw; p++) e = (e * k) >> 16;
    return e;
  endfunction

  function automatic void mix_down();
    int unsigned     n, tc, start;
    longint unsigned total, den, pk, max_amp, a, b, w, e, lg, rg, env;
    longint          vl, vr;
    int              pw;
    trk_cfg_t        c;
    n = n_reg > MaxFrames ? MaxFrames : n_reg;
    tc = tc_reg > MaxTracks ? MaxTracks : tc_reg;
    total = 0;
    pk = 0;
    for (int i = 0; i < MaxFrames; i++) begin
      mix_l[i] = 0;
      mix_r[i] = 0;
    end
    for (int t = 0; t < tc; t++) total += trk_set[t].amp;
    den = total > 256 ? total : 256;
    for (int t = 0; t < tc; t++) begin
      c = trk_set[t];
      if (!c.present || c.offset >= n) continue;
      max_amp = 0;
      for (int i = c.offset; i < n; i++) begin
        a = smp_l[t][i] < 0 ? -longint'(smp_l[t][i]) : smp_l[t][i];
        b = smp_r[t][i] < 0 ? -longint'(smp_r[t][i]) : smp_r[t][i];
        if (a < b) a = b;
        if (a > max_amp) max_amp = a;
      end
      if (max_amp == 0) continue;
      w = (longint'(c.amp) << 16) / den;
      e = (w << 16) / max_amp;
      start = n > c.fout ? n - c.fout : 0;
      lg = c.pan < 0 ? 32768 : 32768 - longint'(c.pan);
      rg = c.pan > 0 ? 32768 : 32768 + longint'(c.pan);
      for (int i = c.offset; i < n; i++) begin
        vl = trunc_scale(smp_l[t][i], e, 8);
        vr = trunc_scale(smp_r[t][i], e, 8);
        env = 65536;
        if (c.fin > 0 && i < c.offset + c.fin) begin
          env = env_pow(i - c.offset, c.fin, 2);
        end else if (c.fout > 0 && i >= start) begin
          pw = c.curve == 3'd4 ? 4 : (c.curve == 3'd2 ? 2 : 3);
          env = env_pow(c.fout - (i - start), c.fout, pw);
        end
        mix_l[i] = int'(mix_l[i] + trunc_scale(vl, env * lg, 31));
        mix_r[i] = int'(mix_r[i] + trunc_scale(vr, env * rg, 31));
      end
    end
    for (int i = 0; i < n; i++) begin
      a = mix_l[i] < 0 ? -longint'(mix_l[i]) : mix_l[i];
      b = mix_r[i] < 0 ? -longint'(mix_r[i]) : mix_r[i];
      if (a > pk) pk = a;
      if (b > pk) pk = b;
    end
    peak_reg = pk;
    out_scale = pk > 64'd16777216 ? (longint'(mg_reg) << 36) / pk : longint'(mg_reg) << 12;
    mix_done = 1'b1;
  endfunction

  function automatic logic [15:0] sat_sample(int m);
    longint v;
    v = trunc_scale(m, out_scale, 49 - SampleBits);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] peak_word();
    longint unsigned p;
    p = peak_reg >> 9;
    return p > 65535 ? 16'hffff : p[15:0];
  endfunction

  // applies one accepted word to the predictor state and returns its result
  function automatic mix_word_t predict_word(kind_e k, logic [127:0] d);
    mix_word_t   o;
    logic [2:0]  t;
    logic [11:0] ix;
    int unsigned n;
    o = '{StatOk, 16'd0, 16'd0, 16'd0};
    t = d[2:0];
    ix = d[14:3];
    n = n_reg > MaxFrames ? MaxFrames : n_reg;
    case (k)
      KindSet: begin
        trk_set[t] = '{d[62:47], d[75:63], d[88:76], d[91:89], d[104:92], d[120:105],
                       d[121]};
      end
      KindSample: begin
        smp_l[t][ix] = d[30:15];
        smp_r[t][ix] = d[46:31];
      end
      KindRun: begin
        mix_down();
        o.peak = peak_word();
      end
      default: begin
        if (!mix_done) begin
          o.status = StatNoMix;
        end else if (ix >= n) begin
          o.status = StatRange;
          o.peak = peak_word();
        end else begin
          o.left = sat_sample(mix_l[ix]);
          o.right = sat_sample(mix_r[ix]);
          o.peak = peak_word();
        end
      end
    endcase
    return o;
  endfunction

  function automatic logic [127:0] pack_word(logic [2:0] trk, logic [11:0] idx,
      logic [15:0] l, logic [15:0] r, logic [15:0] amp, logic [12:0] fin,
      logic [12:0] fout, logic [2:0] curve, logic [12:0] off, logic [15:0] pan,
      logic pres);
    return {6'd0, pres, pan, off, curve, fout, fin, amp, r, l, idx, trk};
  endfunction

  function automatic dir_row_t row(kind_e k, int trk, int idx, int l, int r, int amp,
      int fin, int fout, int curve, int off, int pan, int pres, bit typed,
      status_e st);
    dir_row_t x;
    x = '{k, trk, idx, l, r, amp, fin, fout, curve, off, pan, pres, typed, st};
    return x;
  endfunction

  function automatic int gap_len();
    int u;
    if (quiet) return 0;
    u = $urandom_range(0, 99);
    if (u < 60) return 0;
    if (u < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(kind_e k, logic [127:0] d, bit typed, mix_word_t given);
    int        g;
    mix_word_t p;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_word(k, d);
    pending_words.push_back(typed ? given : p);
    items_sent++;
  endtask

  task automatic send_pred(kind_e k, logic [127:0] d);
    send_word(k, d, 1'b0, '{StatOk, 16'd0, 16'd0, 16'd0});
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e ix, int unsigned v);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= v[15:0];
    do @(posedge clk_i); while (!cfg_ready);
    case (ix)
      CfgTrackCount: tc_reg = v & 4'hf;
      CfgSampleCount: n_reg = v & 13'h1fff;
      CfgMasterGain: mg_reg = v & 16'hffff;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample(int mode);
    case (mode)
      0: return 16'd0;
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_sample(int t, int i, int mode);
    send_pred(KindSample, pack_word(t, i, rand_sample(mode), rand_sample(mode), $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    smp_written[t][i] = 1'b1;
  endtask

  task automatic random_phase();
    int unsigned n_eff, tc_eff, n_val, tc_val, mg_val, off, fl, amp;
    int          u, mode, reads;
    int          order [3];
    bit          pres;
    u = $urandom_range(0, 99);
    if (u < 5) n_val = 0;
    else if (u < 9) n_val = 4096;
    else if (u < 12) n_val = $urandom_range(4097, 8191);
    else if (u < 30) n_val = $urandom_range(1, 4);
    else n_val = $urandom_range(5, 40);
    u = $urandom_range(0, 99);
    if (u < 5) tc_val = 0;
    else if (u < 12) tc_val = $urandom_range(9, 15);
    else if (u < 30) tc_val = 8;
    else tc_val = $urandom_range(1, 7);
    u = $urandom_range(0, 9);
    mg_val = u == 0 ? 0 : (u == 1 ? 65535 : (u < 5 ? 4096 : $urandom_range(0, 65535)));
    quiet = $urandom_range(0, 4) == 0;
    wait_idle();
    order = '{0, 1, 2};
    order.shuffle();
    foreach (order[j]) begin
      case (order[j])
        0: cfg_write(CfgTrackCount, tc_val);
        1: cfg_write(CfgSampleCount, n_val);
        default: cfg_write(CfgMasterGain, mg_val);
      endcase
    end
    n_eff = n_val > MaxFrames ? MaxFrames : n_val;
    tc_eff = tc_val > MaxTracks ? MaxTracks : tc_val;
    if ($urandom_range(0, 3) == 0)
      send_pred(KindRead, pack_word($urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    for (int t = 0; t < MaxTracks; t++) begin
      if (t >= tc_eff && $urandom_range(0, 3) != 0) continue;
      pres = $urandom_range(0, 5) != 0;
      u = $urandom_range(0, 9);
      off = u == 0 ? 4096 : (u == 1 ? $urandom_range(0, 4096) :
            (n_eff > 1 ? $urandom_range(0, n_eff / 2) : 0));
      if (n_eff >= MaxFrames) off = 4096;
      u = $urandom_range(0, 2);
      amp = u == 0 ? $urandom_range(0, 65535) :
            (u == 1 ? $urandom_range(0, 128) : ($urandom_range(0, 1) ? 0 : 65535));
      u = $urandom_range(0, 9);
      fl = u == 0 ? 4096 : (u == 1 ? $urandom_range(0, 4096) : $urandom_range(0, n_eff + 4));
      send_pred(KindSet, pack_word(t, $urandom, $urandom, $urandom, amp, fl,
                $urandom_range(0, 9) == 0 ? 4096 : $urandom_range(0, n_eff + 4),
                $urandom_range(0, 7), off, $urandom, pres));
      if (pres && off < n_eff) begin
        mode = $urandom_range(0, 7);
        for (int i = off; i < n_eff; i++)
          if (!smp_written[t][i] || $urandom_range(0, 3) == 0) write_sample(t, i, mode);
      end
    end
    repeat ($urandom_range(0, 4)) begin
      write_sample($urandom_range(0, 7),
                   $urandom_range(0, 4) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 63),
                   $urandom_range(1, 7));
    end
    send_pred(KindRun, pack_word($urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    reads = n_eff > 40 ? 24 : n_eff + 4;
    for (int j = 0; j < reads; j++) begin
      u = $urandom_range(0, 9);
      send_pred(KindRead, pack_word($urandom,
                u == 0 ? $urandom_range(0, 4095) :
                (n_eff > 0 && u > 1 ? $urandom_range(0, n_eff - 1) : $urandom_range(0, 63)),
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom));
    end
  endtask

  // result word checking and receiver idling
  always @(posedge clk_i) begin
    mix_word_t e;
    logic [1:0] st;
    logic [15:0] lo, ro, po;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      st = m_axis_tdata[1:0];
      lo = m_axis_tdata[17:2];
      ro = m_axis_tdata[33:18];
      po = m_axis_tdata[49:34];
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("result word with none expected");
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (st !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, st);
          errors++;
        end
        if (lo !== e.left) begin
          $error("left_out: expected %0d, actual %0d", $signed(e.left), $signed(lo));
          errors++;
        end
        if (ro !== e.right) begin
          $error("right_out: expected %0d, actual %0d", $signed(e.right), $signed(ro));
          errors++;
        end
        if (po !== e.peak) begin
          $error("global_peak: expected %0d, actual %0d", e.peak, po);
          errors++;
        end
      end
    end
    if (words_seen == 40 && !big_stall_done) begin
      big_stall_done = 1'b1;
      hold = 400;
    end else if (hold == 0 && !quiet && $urandom_range(0, 63) == 0) begin
      hold = $urandom_range(10, 40);
    end
    if (hold > 0) begin
      hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    dir_row_t  tbl[$];
    mix_word_t given;
    tc_reg = 0;
    n_reg = 0;
    mg_reg = 4096;
    mix_done = 1'b0;
    peak_reg = 0;
    out_scale = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tbl.push_back(row(KindRead, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, StatNoMix));
    tbl.push_back(row(KindSet, 0, 0, 0, 0, 65535, 4, 4, 4, 0, -32768, 1, 1, StatOk));
    tbl.push_back(row(KindSet, 1, 0, 0, 0, 0, 0, 4096, 2, 7, 32767, 1, 1, StatOk));
    tbl.push_back(row(KindSet, 2, 0, 0, 0, 256, 4096, 0, 3, 4096, 0, 0, 1, StatOk));
    for (int i = 0; i < 8; i++)
      tbl.push_back(row(KindSample, 0, i, i[0] ? 32767 : -32768, i * 1000 - 4000, 0, 0, 0,
                        0, 0, 0, 0, 1, StatOk));
    tbl.push_back(row(KindSample, 1, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, StatOk));
    tbl.push_back(row(KindSample, 7, 4095, -1, 32767, 0, 0, 0, 0, 0, 0, 0, 1, StatOk));
    tbl.push_back(row(KindRun, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, StatOk));
    foreach (tbl[j]) if (0) ;
    for (int i = 0; i < 9; i++)
      tbl.push_back(row(KindRead, 0, i, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, StatOk));
    tbl.push_back(row(KindRead, 0, 4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, StatOk));

    foreach (tbl[j]) begin
      if (j == 1) begin
        wait_idle();
        cfg_write(CfgTrackCount, 3);
        cfg_write(CfgSampleCount, 8);
        cfg_write(CfgMasterGain, 4096);
      end
      given = '{tbl[j].stat, 16'd0, 16'd0, 16'd0};
      send_word(tbl[j].kind, pack_word(tbl[j].trk, tbl[j].idx, tbl[j].l, tbl[j].r,
                tbl[j].amp, tbl[j].fin, tbl[j].fout, tbl[j].curve, tbl[j].off,
                tbl[j].pan, tbl[j].pres), tbl[j].typed, given);
    end

    while (items_sent < 1050) random_phase();

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
